### rtl/xmw_pkg.sv
// ----------------------------------------------------------------------------
// xmw_pkg
// Shared types, sizes, codes and the exp(-x) threshold table of the walker.
// ----------------------------------------------------------------------------
package xmw_pkg;

  localparam int VAR_COUNT       = 256;
  localparam int CONS_COUNT      = 64;
  localparam int EXP_TABLE_DEPTH = 256;

  localparam int VAR_AW   = $clog2(VAR_COUNT);
  localparam int CNT_W    = $clog2(CONS_COUNT + 1);
  localparam int ROW_W    = CONS_COUNT + 1;        // row bits plus assignment bit on top
  localparam int TAB_AW   = $clog2(EXP_TABLE_DEPTH);
  localparam int PC_CHUNKS = (CONS_COUNT + 7) / 8;

  // fixed field widths
  localparam int ACTION_W   = 2;
  localparam int IDX_W      = 8;
  localparam int ROWBITS_W  = 64;
  localparam int BETA_W     = 16;
  localparam int RAND_W     = 16;
  localparam int THR_W      = 16;
  localparam int DELTA_W    = 8;
  localparam int VIOL_W     = 7;
  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;

  localparam int PROD_W   = BETA_W + CNT_W;
  localparam int EXP_FRAC = 4;                     // beta*delta is in 1/256, table step 1/16

  localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;

  typedef enum logic [ACTION_W-1:0] {
    ACT_RESTART = 2'd0,
    ACT_LOAD    = 2'd1,
    ACT_STEP    = 2'd2,
    ACT_NOP     = 2'd3
  } action_e;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_PARITY = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANNEAL_MODE   = 8'd1;

  typedef struct packed {
    logic load_chunks;
    logic load_sum;
  } pc_ctrl_t;

  typedef logic [EXP_TABLE_DEPTH-1:0][THR_W-1:0] exp_tab_t;

  // entry i ~ 65536*exp(-i/16), saturated to 16 bits
  function automatic exp_tab_t build_exp_table();
    logic [63:0] v;
    logic [63:0] t;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] ph;
    logic [63:0] pl;
    exp_tab_t    tab;
    v = 64'h1_0000_0000;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      t      = (v + 64'd32768) >> 16;
      tab[i] = (t > 64'd65535) ? 16'hFFFF : t[THR_W-1:0];
      hi     = v >> 16;
      lo     = v & 64'hFFFF;
      ph     = hi * EXP_STEP_Q32;
      pl     = lo * EXP_STEP_Q32;
      v      = (ph + ((pl + 64'd32768) >> 16) + 64'd32768) >> 16;
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TABLE = build_exp_table();

endpackage

### rtl/xmw_ram.sv
// ----------------------------------------------------------------------------
// xmw_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module xmw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/xmw_popcnt.sv
// ----------------------------------------------------------------------------
// xmw_popcnt
// Two-stage population count: byte counts, then their sum.
// ----------------------------------------------------------------------------
module xmw_popcnt (
  input  logic                            clk_i,
  input  xmw_pkg::pc_ctrl_t               ctrl_i,
  input  logic [xmw_pkg::CONS_COUNT-1:0]  vec_i,
  output logic [xmw_pkg::CNT_W-1:0]       cnt_o
);
  import xmw_pkg::*;

  localparam int PAD_W = PC_CHUNKS * 8;

  logic [PAD_W-1:0]             padded;
  logic [PC_CHUNKS-1:0][3:0]    part_d;
  logic [PC_CHUNKS-1:0][3:0]    part_q;
  logic [CNT_W-1:0]             cnt_d;
  logic [CNT_W-1:0]             cnt_q;

  assign padded = PAD_W'(vec_i);

  always_comb begin
    part_d = '0;
    for (int c = 0; c < PC_CHUNKS; c++) begin
      for (int b = 0; b < 8; b++) begin
        part_d[c] = part_d[c] + 4'(padded[c*8 + b]);
      end
    end
  end

  always_comb begin
    cnt_d = '0;
    for (int c = 0; c < PC_CHUNKS; c++) begin
      cnt_d = cnt_d + CNT_W'(part_q[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_chunks) begin
      part_q <= part_d;
    end
    if (ctrl_i.load_sum) begin
      cnt_q <= cnt_d;
    end
  end

  assign cnt_o = cnt_q;

endmodule

### rtl/xorsat_metropolis_walker_top.sv
// Each item passes S_IDLE (accept), S_POP1, S_POP2, S_DECIDE and S_APPLY (5 states).
// A new item is taken only after the last commits, which waits on m_axis back-pressure;
//   the row read, two-stage popcount, delta/multiply and commit read-modify-write set the pace.
// A finished result may wait in the output register while the next item is accepted.
// Reset (rst_ni low, async): control, syndrome, counts, config and assignment valid
//   flags clear; the row memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// xorsat_metropolis_walker_top
// Max-XORSAT local-search engine: restart, row load and Metropolis flip steps.
// ----------------------------------------------------------------------------
module xorsat_metropolis_walker_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // input stream
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [7:0] var_sel, [71:8] row_bits, [72] init_bit, [88:73] beta,
  // [104:89] random_word, [111:105] zero
  input  logic [xmw_pkg::IN_TDATA_W-1:0]       s_axis_tdata_i,
  // [1:0] action
  input  logic [xmw_pkg::ACTION_W-1:0]         s_axis_tuser_i,
  // result stream
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // [7:0] delta, [8] flip_taken, [15:9] violated, [22:16] best_violated,
  // [23] var_value
  output logic [xmw_pkg::OUT_TDATA_W-1:0]      m_axis_tdata_o,
  // configuration writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [xmw_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [xmw_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import xmw_pkg::*;

  // input field positions inside tdata
  localparam int IN_VAR_LSB  = 0;
  localparam int IN_ROW_LSB  = IN_VAR_LSB + IDX_W;
  localparam int IN_INIT_LSB = IN_ROW_LSB + ROWBITS_W;
  localparam int IN_BETA_LSB = IN_INIT_LSB + 1;
  localparam int IN_RAND_LSB = IN_BETA_LSB + BETA_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_POP1   = 5'b00010,   // row data back from memory, candidate syndrome formed
    S_POP2   = 5'b00100,   // popcount sum
    S_DECIDE = 5'b01000,   // delta and beta*delta
    S_APPLY  = 5'b10000    // threshold lookup, accept, write back, load result
  } state_e;

  state_e state_q, state_d;

  // config
  logic [CONS_COUNT-1:0] tgt_q, tgt_d;
  logic                  anneal_q, anneal_d;

  // architectural state
  logic [CONS_COUNT-1:0] syn_q, syn_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CNT_W-1:0]      best_q, best_d;
  logic [VAR_COUNT-1:0]  vld_q, vld_d;    // assignment bit written since restart

  // item registers
  action_e               act_q;
  logic [VAR_AW-1:0]     idx_q;
  logic                  ok_q;
  logic [CONS_COUNT-1:0] row_in_q;
  logic                  init_q;
  logic [BETA_W-1:0]     beta_q;
  logic [RAND_W-1:0]     rnd_q;

  // work registers
  logic [CONS_COUNT-1:0]     row_q;
  logic                      bit_q;
  logic [CONS_COUNT-1:0]     cand_q, cand_d;
  logic signed [DELTA_W-1:0] delta_q, delta_d;
  logic [PROD_W-1:0]         prod_q, prod_d;

  // output register
  logic                   m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_data_q, m_data_d;

  logic                in_acc;
  logic                out_free;
  logic                commit;
  logic                is_rst, is_load, is_step, upd, accept;
  logic [PROD_W-EXP_FRAC-1:0] thr_idx;
  logic [THR_W-1:0]    thr;
  logic                ram_we;
  logic [ROW_W-1:0]    ram_wdata;
  logic [ROW_W-1:0]    ram_rdata;
  logic [CNT_W-1:0]    nw;
  logic [CNT_W-1:0]    dmag;
  logic                cur_bit;
  logic                var_val;
  pc_ctrl_t            pc_ctrl;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign commit          = (state_q == S_APPLY) && out_free;

  // row memory: {assignment bit, row}; read for every item at acceptance
  xmw_ram #(
    .WIDTH (ROW_W),
    .DEPTH (VAR_COUNT)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .re_i    (in_acc),
    .raddr_i (VAR_AW'(s_axis_tdata_i[IN_VAR_LSB +: IDX_W])),
    .rdata_o (ram_rdata)
  );

  assign pc_ctrl.load_chunks = (state_q == S_POP1);
  assign pc_ctrl.load_sum    = (state_q == S_POP2);

  xmw_popcnt u_popcnt (
    .clk_i  (clk_i),
    .ctrl_i (pc_ctrl),
    .vec_i  (cand_d),
    .cnt_o  (nw)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (in_acc) state_d = S_POP1;
      S_POP1:   state_d = S_POP2;
      S_POP2:   state_d = S_DECIDE;
      S_DECIDE: state_d = S_APPLY;
      S_APPLY:  if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // config writes
  always_comb begin
    tgt_d    = tgt_q;
    anneal_d = anneal_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_TARGET_PARITY: tgt_d    = cfg_data_i[CONS_COUNT-1:0];
        REG_ANNEAL_MODE:   anneal_d = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign is_rst  = (act_q == ACT_RESTART);
  assign is_load = (act_q == ACT_LOAD) && ok_q;
  assign is_step = (act_q == ACT_STEP) && ok_q;

  // candidate syndrome, formed when the row comes back
  assign cur_bit = vld_q[idx_q] && ram_rdata[CONS_COUNT];
  always_comb begin
    cand_d = syn_q;
    if (is_rst) begin
      cand_d = tgt_q;
    end else if (is_load && init_q) begin
      cand_d = syn_q ^ row_in_q;
    end else if (is_step) begin
      cand_d = syn_q ^ ram_rdata[CONS_COUNT-1:0];
    end
  end

  // delta and Metropolis exponent argument
  assign delta_d = $signed(DELTA_W'(nw)) - $signed(DELTA_W'(cnt_q));
  assign dmag    = delta_d[CNT_W-1:0];
  assign prod_d  = PROD_W'(beta_q) * PROD_W'(dmag);

  // saturating threshold lookup: index past the table means threshold zero
  assign thr_idx = prod_q[PROD_W-1:EXP_FRAC];
  assign thr     = (32'(thr_idx) < 32'(EXP_TABLE_DEPTH)) ?
                   EXP_TABLE[thr_idx[TAB_AW-1:0]] : '0;
  assign accept  = (delta_q <= 0) || (anneal_q && (rnd_q < thr));
  assign upd     = is_rst || is_load || (is_step && accept);

  assign ram_we    = commit && (is_load || (is_step && accept));
  assign ram_wdata = is_load ? {init_q, row_in_q} : {~bit_q, row_q};

  always_comb begin
    syn_d  = syn_q;
    cnt_d  = cnt_q;
    best_d = best_q;
    vld_d  = vld_q;
    if (commit && upd) begin
      syn_d = cand_q;
      cnt_d = nw;
      if (is_rst || (nw < best_q)) begin
        best_d = nw;
      end
    end
    if (commit && is_rst) begin
      vld_d = '0;
    end else if (ram_we) begin
      vld_d[idx_q] = 1'b1;
    end
  end

  // result assembly
  always_comb begin
    var_val = 1'b0;
    if (is_load) begin
      var_val = init_q;
    end else if (is_step) begin
      var_val = bit_q ^ accept;
    end else if (!is_rst) begin
      var_val = ok_q && bit_q;
    end
    m_data_d = {var_val,
                VIOL_W'(best_d),
                VIOL_W'(cnt_d),
                is_step && accept,
                is_step ? delta_q : DELTA_W'(0)};
    m_valid_d = m_valid_q && !m_axis_tready_i;
    if (commit) begin
      m_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      tgt_q     <= '0;
      anneal_q  <= 1'b0;
      syn_q     <= '0;
      cnt_q     <= '0;
      best_q    <= '0;
      vld_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      tgt_q     <= tgt_d;
      anneal_q  <= anneal_d;
      syn_q     <= syn_d;
      cnt_q     <= cnt_d;
      best_q    <= best_d;
      vld_q     <= vld_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q    <= action_e'(s_axis_tuser_i);
      idx_q    <= VAR_AW'(s_axis_tdata_i[IN_VAR_LSB +: IDX_W]);
      ok_q     <= 32'(s_axis_tdata_i[IN_VAR_LSB +: IDX_W]) < 32'(VAR_COUNT);
      row_in_q <= s_axis_tdata_i[IN_ROW_LSB +: CONS_COUNT];
      init_q   <= s_axis_tdata_i[IN_INIT_LSB];
      beta_q   <= s_axis_tdata_i[IN_BETA_LSB +: BETA_W];
      rnd_q    <= s_axis_tdata_i[IN_RAND_LSB +: RAND_W];
    end
    if (state_q == S_POP1) begin
      row_q  <= ram_rdata[CONS_COUNT-1:0];
      bit_q  <= cur_bit;
      cand_q <= cand_d;
    end
    if (state_q == S_DECIDE) begin
      delta_q <= delta_d;
      prod_q  <= prod_d;
    end
    if (commit) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

`ifndef SYNTH
  // best count never exceeds the current violated count in a delivered result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[22:16] <= m_axis_tdata_o[15:9]))
    else $error("best_violated above violated");

  // a worsening flip is taken only in anneal mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && is_step && accept && (delta_q > 0)) |-> anneal_q)
    else $error("worsening flip taken in greedy mode");

  // syndrome changes only at commit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_APPLY) |=> $stable(syn_q))
    else $error("syndrome changed outside commit");

  // restart clears every assignment valid flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && is_rst) |=> (vld_q == '0))
    else $error("assignment flags not cleared by restart");

  // an accepted transaction starts the row read pass and blocks further input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> ((state_q == S_POP1) && !s_axis_tready_o))
    else $error("input accepted while an item is in flight");
`endif

endmodule

### test/xorsat_metropolis_walker_top_tb.sv
// ----------------------------------------------------------------------------
// xorsat_metropolis_walker_top_tb
// Self-checking bench for the max-XORSAT walker. A short directed sequence
// covers the boundary cases. Phases of random restart, row-load, no-op and
// flip-step transactions follow, each run under its own parity target, with
// greedy and anneal acceptance in turn. A behavioral model in the bench predicts
// every result, and each result is compared field by field. Both streams idle
// at random, but for one calm phase.
// ----------------------------------------------------------------------------
module xorsat_metropolis_walker_top_tb;
  import xmw_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 12;      // extra wait after the last owed result
  localparam int LIMIT_CYCLES  = 250000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 172;
  localparam int REPORT_MAX    = 10;

  localparam logic [63:0] DECAY_Q32 = 64'd4034748382;   // 2^32 * exp(-1/16)
  localparam logic [63:0] ALT_ROW   = 64'hAAAA_AAAA_AAAA_AAAA;

  typedef struct {
    action_e              act;
    logic [IDX_W-1:0]     vidx;
    logic [ROWBITS_W-1:0] row;
    logic                 init;
    logic [BETA_W-1:0]    beta;
    logic [RAND_W-1:0]    rnd;
  } walk_item_t;

  typedef struct {
    logic [DELTA_W-1:0] delta;
    logic               taken;
    logic [VIOL_W-1:0]  viol;
    logic [VIOL_W-1:0]  best;
    logic               value;
  } walk_report_t;

  // walker state mirror and queue of the reports it owes
  class walk_tracker;
    logic [THR_W-1:0]      thresholds[EXP_TABLE_DEPTH];
    logic [CONS_COUNT-1:0] rows[VAR_COUNT];
    bit                    bits[VAR_COUNT];
    logic [CONS_COUNT-1:0] syndrome;
    logic [CONS_COUNT-1:0] parity_target;
    bit                    anneal;
    int                    viol;
    int                    best;
    walk_report_t          due[$];
    int                    faults;
    int                    n_restart, n_load, n_step, n_taken, n_hot, n_nop;

    function new();
      logic [63:0] v;
      logic [63:0] t;
      v = 64'd1 << 32;
      for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
        t = (v + 64'd32768) >> 16;
        thresholds[i] = (t > 64'd65535) ? 16'hFFFF : t[15:0];
        v = ((v >> 16) * DECAY_Q32 + ((((v & 64'hFFFF) * DECAY_Q32) + 64'd32768) >> 16)
             + 64'd32768) >> 16;
      end
      bits          = '{default: 1'b0};
      syndrome      = '0;
      parity_target = '0;
      anneal        = 1'b0;
      viol          = 0;
      best          = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_TARGET_PARITY) parity_target = val[CONS_COUNT-1:0];
      else if (idx == REG_ANNEAL_MODE) anneal = val[0];
    endfunction

    function void fault(string what);
      faults++;
      if (faults <= REPORT_MAX) $display("%s", what);
    endfunction

    // apply one accepted input transaction and queue the report it causes
    function void take_item(walk_item_t it);
      walk_report_t          r;
      logic [CONS_COUNT-1:0] nxt;
      int                    nw;
      int                    dlt;
      int                    idx;
      bit                    ok;
      dlt = 0;
      ok  = 1'b0;
      case (it.act)
        ACT_RESTART: begin
          bits     = '{default: 1'b0};
          syndrome = parity_target;
          viol     = $countones(syndrome);
          best     = viol;
          n_restart++;
        end
        ACT_LOAD: begin
          rows[it.vidx] = it.row[CONS_COUNT-1:0];
          bits[it.vidx] = it.init;
          if (it.init) syndrome ^= it.row[CONS_COUNT-1:0];  // earlier fold is not undone
          viol = $countones(syndrome);
          if (viol < best) best = viol;
          n_load++;
        end
        ACT_STEP: begin
          nxt = syndrome ^ rows[it.vidx];
          nw  = $countones(nxt);
          dlt = nw - viol;
          ok  = (dlt <= 0);
          if (!ok && anneal) begin
            idx = (int'(it.beta) * dlt) >> 4;
            ok  = (idx < EXP_TABLE_DEPTH) ? (it.rnd < thresholds[idx]) : 1'b0;
            n_hot++;
          end
          if (ok) begin
            bits[it.vidx] ^= 1'b1;
            syndrome = nxt;
            viol     = nw;
            if (viol < best) best = viol;
            n_taken++;
          end
          n_step++;
        end
        default: n_nop++;
      endcase
      r.delta = dlt[DELTA_W-1:0];
      r.taken = ok;
      r.viol  = viol[VIOL_W-1:0];
      r.best  = best[VIOL_W-1:0];
      r.value = bits[it.vidx];
      due.insert(due.size(), r);
    endfunction

    // tdata: [7:0] delta, [8] taken, [15:9] violated, [22:16] best, [23] value
    function void match_report(logic [OUT_TDATA_W-1:0] d);
      walk_report_t e;
      if (due.size() == 0) begin
        fault($sformatf("unexpected result %h at %0t", d, $time));
        return;
      end
      e = due.pop_front();
      if (d[7:0] !== e.delta || d[8] !== e.taken || d[15:9] !== e.viol ||
          d[22:16] !== e.best || d[23] !== e.value)
        fault($sformatf({"mismatch at %0t: expected delta %0d taken %0b viol %0d best %0d ",
                         "value %0b, got delta %0d taken %0b viol %0d best %0d value %0b"},
                        $time, $signed(e.delta), e.taken, e.viol, e.best, e.value,
                        $signed(d[7:0]), d[8], d[15:9], d[22:16], d[23]));
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;
  logic [ACTION_W-1:0]    s_axis_tuser_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  walk_tracker tracker = new();
  bit          calm;              // no idling on either stream while set

  xorsat_metropolis_walker_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #HALF_PERIOD;
    clk_i = 1'b1;
    #HALF_PERIOD;
  end

  function automatic walk_item_t walk_item(action_e a, int v, logic [63:0] r, bit b,
                                           int be, int rw);
    walk_item_t it;
    it.act  = a;
    it.vidx = v[IDX_W-1:0];
    it.row  = r;
    it.init = b;
    it.beta = be[BETA_W-1:0];
    it.rnd  = rw[RAND_W-1:0];
    return it;
  endfunction

  function automatic logic [63:0] random_row();
    logic [63:0] a;
    logic [63:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0:       return a;
      1:       return a & b & {$urandom, $urandom};   // sparse: small deltas
      2:       return 64'd1 << $urandom_range(0, 63);
      default: return a | b;
    endcase
  endfunction

  function automatic int random_beta();
    case ($urandom_range(0, 9))
      0:       return ($urandom_range(0, 1) != 0) ? 0 : 65535;
      1, 2:    return $urandom_range(0, 65535);
      3, 4, 5: return $urandom_range(64, 1023);
      default: return $urandom_range(0, 63);
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the transaction
  task automatic send_item(input walk_item_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata_i  <= {{(IN_TDATA_W - 105){1'b0}}, it.rnd, it.beta, it.init, it.row, it.vidx};
    s_axis_tuser_i  <= it.act;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    tracker.take_item(it);
    @(negedge clk_i);
  endtask

  // stop the input stream and let every owed result come out
  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (tracker.due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.set_reg(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic directed_part();
    calm = 1'b0;
    write_reg(REG_TARGET_PARITY, '1);
    write_reg(REG_ANNEAL_MODE, 64'd0);
    send_item(walk_item(ACT_NOP, 0, '0, 0, 0, 0));                 // counts right out of reset
    send_item(walk_item(ACT_RESTART, 255, '1, 1, 65535, 65535));    // every constraint violated
    send_item(walk_item(ACT_LOAD, 0, '1, 0, 0, 0));
    send_item(walk_item(ACT_LOAD, 255, '1, 1, 65535, 65535));       // folds to zero violated
    send_item(walk_item(ACT_LOAD, 1, '0, 0, 0, 0));
    send_item(walk_item(ACT_LOAD, 2, ALT_ROW, 0, 0, 0));
    send_item(walk_item(ACT_LOAD, 3, 64'hF, 1, 0, 0));
    send_item(walk_item(ACT_RESTART, 0, '0, 0, 0, 0));              // rows survive restart
    send_item(walk_item(ACT_STEP, 1, '0, 0, 0, 0));                 // zero row: delta 0
    send_item(walk_item(ACT_STEP, 2, '0, 0, 0, 0));                 // improving flip
    send_item(walk_item(ACT_STEP, 2, '0, 0, 0, 0));                 // worsening, greedy rejects
    send_item(walk_item(ACT_STEP, 0, '0, 0, 0, 0));
    send_item(walk_item(ACT_LOAD, 3, 64'hF, 1, 0, 0));
    send_item(walk_item(ACT_LOAD, 3, 64'hF0, 1, 0, 0));             // reload over a folded row
    send_item(walk_item(ACT_NOP, 2, '1, 1, 65535, 65535));
    drain();
    write_reg(REG_ANNEAL_MODE, 64'd1);
    send_item(walk_item(ACT_STEP, 2, '0, 0, 0, 0));
    send_item(walk_item(ACT_STEP, 2, '0, 0, 0, 65535));             // threshold saturated, rnd max
    send_item(walk_item(ACT_STEP, 2, '0, 0, 0, 65534));
    send_item(walk_item(ACT_STEP, 2, '0, 0, 0, 0));
    send_item(walk_item(ACT_STEP, 2, '0, 0, 65535, 0));             // past table end: threshold 0
    send_item(walk_item(ACT_STEP, 2, '0, 0, 10, 0));
    send_item(walk_item(ACT_STEP, 3, '0, 0, 1, 1));
    send_item(walk_item(ACT_RESTART, 0, '0, 0, 0, 0));
    send_item(walk_item(ACT_NOP, 255, '0, 0, 0, 0));
    drain();
  endtask

  // restart, load a handful of rows, then mostly flip proposals with some noise
  task automatic random_phase(input int ph);
    logic [63:0] tp;
    int          sent;
    int          pick;
    int          v;
    int          vars[$];
    if (ph == 0) tp = '0;
    else if (ph == 1) tp = '1;
    else tp = {$urandom, $urandom};
    calm = (ph == 2);
    write_reg(REG_TARGET_PARITY, tp);
    write_reg(REG_ANNEAL_MODE, {63'd0, ph[0]});
    send_item(walk_item(ACT_RESTART, $urandom_range(0, 255), random_row(),
                        $urandom_range(0, 1), $urandom_range(0, 65535), $urandom_range(0, 65535)));
    sent = 1;
    repeat ($urandom_range(4, 32)) begin
      v = $urandom_range(0, VAR_COUNT - 1);
      vars.insert(vars.size(), v);
      send_item(walk_item(ACT_LOAD, v, random_row(), $urandom_range(0, 1),
                          random_beta(), $urandom_range(0, 65535)));
      sent++;
    end
    while (sent < PHASE_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        v = vars[$urandom_range(0, vars.size() - 1)];
        send_item(walk_item(ACT_STEP, v, random_row(), $urandom_range(0, 1),
                            random_beta(), $urandom_range(0, 65535)));
      end else if (pick < 90) begin
        v = $urandom_range(0, VAR_COUNT - 1);
        vars.insert(vars.size(), v);
        send_item(walk_item(ACT_LOAD, v, random_row(), $urandom_range(0, 1),
                            random_beta(), $urandom_range(0, 65535)));
      end else if (pick < 97) begin
        send_item(walk_item(ACT_NOP, $urandom_range(0, 255), random_row(),
                            $urandom_range(0, 1), random_beta(), $urandom_range(0, 65535)));
      end else begin
        send_item(walk_item(ACT_RESTART, $urandom_range(0, 255), random_row(),
                            $urandom_range(0, 1), random_beta(), $urandom_range(0, 65535)));
      end
      sent++;
    end
    drain();
  endtask

  // result side backpressure
  initial begin : result_sink
    int gap;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) tracker.match_report(m_axis_tdata_o);
  end

  initial begin : stimulus
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = ACT_NOP;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = REG_TARGET_PARITY;
    cfg_data_i      = '0;
    calm            = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);
    directed_part();
    for (int ph = 0; ph < RANDOM_PHASES; ph++) random_phase(ph);
    $display("walker run: %0d restarts, %0d row loads, %0d no-ops, %0d flip proposals",
             tracker.n_restart, tracker.n_load, tracker.n_nop, tracker.n_step);
    $display("  %0d flips taken, %0d worsening proposals judged by threshold, %0d faults",
             tracker.n_taken, tracker.n_hot, tracker.faults);
    if (tracker.faults == 0) begin
      $display("xorsat_metropolis_walker_top_tb: done, clean");
    end else begin
      $display("xorsat_metropolis_walker_top_tb: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("xorsat_metropolis_walker_top_tb: done, errors");
    $finish;
  end

endmodule
